// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPMB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lpmb_pkg.sv
package lpmb_pkg;

    localparam int STORE_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int KIND_W   = 2;
    localparam int LEN_W    = 13;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER      = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic                last_of_message;
        logic [LEN_W-1:0]    message_size;
    } t_result;

endpackage

// File: rtl/core/length_prefixed_message_buffer.sv
// Path of a request: byte writes and refused requests go to S_RESULT; a read inside
//   a message passes S_PAY; an accepted start, S_HDR_WR; a read that opens a message,
//   S_HDR_RD0, S_HDR_RD1, S_PAY (not S_PAY if empty), fetching the header through the
//   store's one port; then the output register. Requests stall until S_RESULT is left.
// Reset: i_rst_n synchronous, active low; clears offsets, counts and handshakes.
//   The byte store is not cleared.
module length_prefixed_message_buffer #(
    parameter int STORE_BYTES  = lpmb_pkg::STORE_BYTES_DEF,
    parameter int HEADER_BYTES = lpmb_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpmb_pkg::KIND_W-1:0]   i_kind,
    input  logic [lpmb_pkg::LEN_W-1:0]    i_msg_length,
    input  logic [lpmb_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpmb_pkg::STATUS_W-1:0] o_status,
    output logic [lpmb_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last_of_message,
    output logic [lpmb_pkg::LEN_W-1:0]    o_message_size
);

    import lpmb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic              res_valid;
    logic              res_take;
    t_result           res;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic              r_out_valid;
    t_result           r_out;

    lpmb_ctrl #(
        .STORE_BYTES  (STORE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_msg_length (i_msg_length),
        .i_data_byte  (i_data_byte),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res),
        .o_ram_we     (ram_we),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .i_ram_rdata  (ram_rdata)
    );

    lpmb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_out_byte        = r_out.out_byte;
    assign o_last_of_message = r_out.last_of_message;
    assign o_message_size    = r_out.message_size;

endmodule

// File: rtl/core/lpmb_ram.sv
module lpmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lpmb_ctrl.sv
module lpmb_ctrl #(
    parameter int STORE_BYTES  = lpmb_pkg::STORE_BYTES_DEF,
    parameter int HEADER_BYTES = lpmb_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lpmb_pkg::KIND_W-1:0]    i_kind,
    input  logic [lpmb_pkg::LEN_W-1:0]     i_msg_length,
    input  logic [lpmb_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output lpmb_pkg::t_result              o_res,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_BYTES)-1:0] o_ram_addr,
    output logic [lpmb_pkg::BYTE_W-1:0]    o_ram_wdata,
    input  logic [lpmb_pkg::BYTE_W-1:0]    i_ram_rdata
);

    import lpmb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int HW = $clog2(HEADER_BYTES);
    localparam int CW = $clog2(STORE_BYTES / HEADER_BYTES + 1);

    localparam logic [SW-1:0] STORE_S = SW'(STORE_BYTES);
    localparam logic [SW-1:0] HDR_S   = SW'(HEADER_BYTES);
    localparam logic [PW-1:0] HDR_P   = PW'(HEADER_BYTES);
    localparam logic [HW-1:0] HDR_TOP = HW'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_WR,
        S_HDR_RD0,
        S_HDR_RD1,
        S_PAY,
        S_RESULT
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_wpos, n_wpos;
    logic [PW-1:0]     r_rpos, n_rpos;
    logic [CW-1:0]     r_ready, n_ready;
    logic [LEN_W-1:0]  r_wleft, n_wleft;
    logic              r_wopen, n_wopen;
    logic [LEN_W-1:0]  r_wlen, n_wlen;
    logic [AW-1:0]     r_waddr, n_waddr;
    logic [LEN_W-1:0]  r_rleft, n_rleft;
    logic [LEN_W-1:0]  r_rlen, n_rlen;
    logic [HW-1:0]     r_hdr_idx, n_hdr_idx;
    logic [AW-1:0]     r_hdr_base, n_hdr_base;
    logic [LEN_W-1:0]  r_hdr_len, n_hdr_len;
    logic [BYTE_W-1:0] r_b0, n_b0;
    t_result           r_res, n_res;

    logic              accept;
    logic              fin;
    logic [LEN_W-1:0]  hdr_len;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;
    assign hdr_len     = {i_ram_rdata[LEN_W-BYTE_W-1:0], r_b0};

    always_comb begin
        n_state    = r_state;
        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        n_ready    = r_ready;
        n_wleft    = r_wleft;
        n_wopen    = r_wopen;
        n_wlen     = r_wlen;
        n_waddr    = r_waddr;
        n_rleft    = r_rleft;
        n_rlen     = r_rlen;
        n_hdr_idx  = r_hdr_idx;
        n_hdr_base = r_hdr_base;
        n_hdr_len  = r_hdr_len;
        n_b0       = r_b0;
        n_res      = r_res;
        fin        = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_rpos[AW-1:0];
        o_ram_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res        = '0;
                    n_res.status = ST_ORDER;
                    n_state      = S_RESULT;
                    case (i_kind)
                        KIND_START: begin
                            if (!r_wopen) begin
                                n_res.message_size = i_msg_length;
                                if (SW'(r_wpos) + HDR_S + SW'(i_msg_length) > STORE_S) begin
                                    n_res.status = ST_NO_ROOM;
                                end else begin
                                    n_res.status = ST_OK;
                                    n_hdr_base   = r_wpos[AW-1:0];
                                    n_hdr_len    = i_msg_length;
                                    n_hdr_idx    = '0;
                                    n_state      = S_HDR_WR;
                                    if (i_msg_length == '0) begin
                                        n_wpos  = r_wpos + HDR_P;
                                        n_ready = r_ready + CW'(1);
                                    end else begin
                                        n_wleft = i_msg_length;
                                        n_wlen  = i_msg_length;
                                        n_wopen = 1'b1;
                                        n_waddr = AW'(SW'(r_wpos) + HDR_S);
                                    end
                                end
                            end
                        end
                        KIND_BYTE: begin
                            if (r_wopen) begin
                                o_ram_we           = 1'b1;
                                o_ram_addr         = r_waddr;
                                o_ram_wdata        = i_data_byte;
                                n_waddr            = r_waddr + AW'(1);
                                n_wleft            = r_wleft - LEN_W'(1);
                                n_res.status       = ST_OK;
                                n_res.message_size = r_wlen;
                                // close the message on its final byte
                                if (r_wleft == LEN_W'(1)) begin
                                    n_wopen = 1'b0;
                                    n_wpos  = PW'(SW'(r_wpos) + HDR_S + SW'(r_wlen));
                                    n_ready = r_ready + CW'(1);
                                end
                            end
                        end
                        KIND_READ: begin
                            if (r_rleft == '0 && r_ready == '0) begin
                                n_res.status = ST_NONE_READY;
                            end else begin
                                n_res.status = ST_OK;
                                n_state = (r_rleft == '0) ? S_HDR_RD0 : S_PAY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR_WR: begin
                o_ram_we   = 1'b1;
                o_ram_addr = r_hdr_base + AW'(r_hdr_idx);
                if (r_hdr_idx == '0) begin
                    o_ram_wdata = r_hdr_len[BYTE_W-1:0];
                end else if (r_hdr_idx == HW'(1)) begin
                    o_ram_wdata = BYTE_W'(r_hdr_len >> BYTE_W);
                end
                n_hdr_idx = r_hdr_idx + HW'(1);
                if (r_hdr_idx == HDR_TOP) begin
                    n_state = S_RESULT;
                end
            end
            S_HDR_RD0: begin
                o_ram_addr = r_rpos[AW-1:0] + AW'(1);
                n_b0       = i_ram_rdata;
                n_state    = S_HDR_RD1;
            end
            S_HDR_RD1: begin
                n_rlen             = hdr_len;
                n_rpos             = r_rpos + HDR_P;
                n_res.message_size = hdr_len;
                if (hdr_len == '0) begin
                    n_res.last_of_message = 1'b1;
                    fin     = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    n_rleft    = hdr_len;
                    o_ram_addr = AW'(r_rpos + HDR_P);
                    n_state    = S_PAY;
                end
            end
            S_PAY: begin
                n_res.out_byte     = i_ram_rdata;
                n_res.message_size = r_rlen;
                n_rpos             = r_rpos + PW'(1);
                n_rleft            = r_rleft - LEN_W'(1);
                if (r_rleft == LEN_W'(1)) begin
                    n_res.last_of_message = 1'b1;
                    fin = 1'b1;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // message fully read: retire it, rewind the store once empty and no write is open
        if (fin) begin
            if (r_ready != '0) begin
                n_ready = r_ready - CW'(1);
            end
            if (n_ready == '0 && !r_wopen) begin
                n_rpos = '0;
                n_wpos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wpos  <= '0;
            r_rpos  <= '0;
            r_ready <= '0;
            r_wleft <= '0;
            r_wopen <= 1'b0;
            r_rleft <= '0;
            r_rlen  <= '0;
        end else begin
            r_state <= n_state;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
            r_ready <= n_ready;
            r_wleft <= n_wleft;
            r_wopen <= n_wopen;
            r_rleft <= n_rleft;
            r_rlen  <= n_rlen;
        end
        r_wlen     <= n_wlen;
        r_waddr    <= n_waddr;
        r_hdr_idx  <= n_hdr_idx;
        r_hdr_base <= n_hdr_base;
        r_hdr_len  <= n_hdr_len;
        r_b0       <= n_b0;
        r_res      <= n_res;
    end

endmodule

// File: rtl/core/lpmb_checker.sv
`include "assert_macros.svh"

module lpmb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [lpmb_pkg::STATUS_W-1:0] o_status,
    input  logic [lpmb_pkg::BYTE_W-1:0]   o_out_byte,
    input  logic                          o_last_of_message,
    input  logic [lpmb_pkg::LEN_W-1:0]    o_message_size
);

    import lpmb_pkg::*;

    logic                             in_acc;
    logic                             out_err;
    logic                             out_no_msg;
    logic                             data_clear;
    logic                             size_clear;
    logic                             out_held;
    logic [STATUS_W+BYTE_W+LEN_W+1:0] out_word;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_err    = o_out_valid && (o_status != ST_OK);
    assign out_no_msg = o_out_valid && (o_status inside {ST_NONE_READY, ST_ORDER});
    assign data_clear = (o_out_byte == '0) && !o_last_of_message;
    assign size_clear = (o_message_size == '0);
    assign out_held   = o_out_valid && i_out_stall;
    assign out_word   = {o_out_valid, o_status, o_out_byte, o_last_of_message, o_message_size};

    // a refused request carries no read byte and no last flag
    `LPMB_ASSERT_IMP(a_err_no_data, i_clk, i_rst_n, out_err, data_clear, "error result has data")

    `LPMB_ASSERT_IMP(a_err_no_size, i_clk, i_rst_n, out_no_msg, size_clear, "error has a size")

    // one request at a time: busy right after an accept
    `LPMB_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "double accept")

    `LPMB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, $stable(out_word), "stall not held")

endmodule

bind length_prefixed_message_buffer lpmb_checker u_lpmb_checker (.*);

// File: test/length_prefixed_message_buffer_tb.sv
module length_prefixed_message_buffer_tb;
    import lpmb_pkg::*;

    localparam int STORE = STORE_BYTES_DEF;
    localparam int HDR = HEADER_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4 * (HDR + 1);
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [KIND_W-1:0] i_kind;
    logic [LEN_W-1:0] i_msg_length;
    logic [BYTE_W-1:0] i_data_byte;
    logic o_out_valid;
    logic i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0] o_out_byte;
    logic o_last_of_message;
    logic [LEN_W-1:0] o_message_size;

    length_prefixed_message_buffer uut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow of the buffer contents and offsets
    bit [7:0] msg_store [STORE];
    int wr_pos, rd_pos, ready_cnt, wr_left, rd_left, rd_len;
    bit wr_open;

    t_result expected_results [$];
    t_result want_result;

    int mismatch_cnt, requests_sent, results_checked, quiet_cycles, long_msgs;
    int kind_count [4];
    int status_count [4];
    bit in_idle_on, quiet_tail;

    function automatic int header_length(int at);
        int len;
        len = 0;
        for (int i = 0; i < HDR && i < 8; i++)
            if (at + i < STORE) len |= int'(msg_store[at + i]) << (8 * i);
        return len & 'h1FFF;
    endfunction

    function automatic void close_read_message();
        if (ready_cnt > 0) ready_cnt--;
        // rewind only when the store is empty and no write holds a place
        if (ready_cnt == 0 && !wr_open) begin
            rd_pos = 0;
            wr_pos = 0;
        end
    endfunction

    function automatic t_result predict_result(logic [KIND_W-1:0] kind,
                                               logic [LEN_W-1:0] len,
                                               logic [BYTE_W-1:0] data);
        t_result r;
        int hdr_len;
        r = '0;
        r.status = ST_ORDER;
        case (kind)
            KIND_START: begin
                if (!wr_open) begin
                    r.message_size = len;
                    if (wr_pos + HDR + int'(len) > STORE) begin
                        r.status = ST_NO_ROOM;
                    end else begin
                        r.status = ST_OK;
                        for (int i = 0; i < HDR; i++)
                            if (wr_pos + i < STORE)
                                msg_store[wr_pos + i] = (i < 4) ? 8'(int'(len) >> (8 * i)) : 8'h00;
                        if (len == 0) begin
                            wr_pos += HDR;
                            ready_cnt++;
                        end else begin
                            wr_left = int'(len);
                            wr_open = 1'b1;
                        end
                    end
                end
            end
            KIND_BYTE: begin
                if (wr_open) begin
                    hdr_len = header_length(wr_pos);
                    if (wr_pos + HDR + hdr_len - wr_left < STORE)
                        msg_store[wr_pos + HDR + hdr_len - wr_left] = data;
                    wr_left--;
                    r.status = ST_OK;
                    r.message_size = LEN_W'(hdr_len);
                    if (wr_left == 0) begin
                        wr_open = 1'b0;
                        wr_pos += HDR + hdr_len;
                        ready_cnt++;
                    end
                end
            end
            KIND_READ: begin
                if (rd_left == 0 && ready_cnt == 0) begin
                    r.status = ST_NONE_READY;
                end else begin
                    r.status = ST_OK;
                    if (rd_left == 0) begin
                        rd_len = header_length(rd_pos);
                        rd_pos += HDR;
                        rd_left = rd_len;
                    end
                    r.message_size = LEN_W'(rd_len);
                    if (rd_left == 0) begin
                        r.last_of_message = 1'b1;
                        close_read_message();
                    end else begin
                        r.out_byte = (rd_pos < STORE) ? msg_store[rd_pos] : 8'h00;
                        rd_pos++;
                        rd_left--;
                        if (rd_left == 0) begin
                            r.last_of_message = 1'b1;
                            close_read_message();
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] data);
        i_kind <= kind;
        i_msg_length <= len;
        i_data_byte <= data;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_result(kind, len, data));
        requests_sent++;
        kind_count[kind]++;
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_start(input int len);
        send_request(KIND_START, len[LEN_W-1:0], BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send_request(KIND_BYTE, LEN_W'($urandom_range(0, 8191)), data);
    endtask

    task automatic send_read();
        send_request(KIND_READ, LEN_W'($urandom_range(0, 8191)),
                     BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_stray();
        send_request(KIND_UNUSED, LEN_W'($urandom_range(0, 8191)),
                     BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 12);
        if (roll < 90) return $urandom_range(13, 120);
        // never fits, whatever the write offset
        if (roll < 97) return $urandom_range(STORE - HDR + 1, 8191);
        if (long_msgs < 2) begin
            long_msgs++;
            return $urandom_range(150, 250);
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_stray();
            1: send_start(pick_length());
            2: send_read();
            default: send_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_directed_cases();
        send_read();
        send_byte(8'hFF);
        send_stray();
        send_start(0);
        send_read();
        send_start(3);
        send_start(13'h1FFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        repeat (3) send_read();
        // drain the only ready message while a second one is still open
        send_start(1);
        send_byte(8'h5A);
        send_start(2);
        send_byte(8'h01);
        send_read();
        send_read();
        send_byte(8'hFE);
        repeat (3) send_read();
        send_start(13'h1FFF);
        send_start(STORE);
        wait_all_results();
    endtask

    task automatic test_room_check();
        // refuse one byte past the end, from an empty store and behind a message
        send_start(STORE - HDR + 1);
        send_start(5);
        repeat (5) send_byte(BYTE_W'($urandom_range(0, 255)));
        send_start(STORE - 2 * HDR - 5 + 1);
        send_start(0);
        send_byte(8'h3C);
        repeat (7) send_read();
        wait_all_results();
    endtask

    task automatic run_traffic(input int target);
        int first, batches;
        first = requests_sent;
        batches = 0;
        while (requests_sent - first < target) begin
            repeat ($urandom_range(1, 5)) begin
                send_start(pick_length());
                while (wr_open) begin
                    if ($urandom_range(0, 11) == 0) send_noise();
                    else send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
            // drain, now and then stopping early so the store fills up
            while ((ready_cnt > 0 || rd_left > 0) && $urandom_range(0, 29) != 0) send_read();
            if ($urandom_range(0, 3) == 0) send_noise();
            batches++;
            if (batches % 6 == 0) wait_all_results();
        end
    endtask

    task automatic test_random_traffic();
        in_idle_on = 1'b1;
        run_traffic(330);
    endtask

    task automatic test_back_to_back();
        in_idle_on = 1'b0;
        quiet_tail = 1'b1;
        run_traffic(50);
    endtask

    task automatic check_field(input string field, input logic [LEN_W-1:0] want_v,
                               input logic [LEN_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d byte %0d",
                         $time, o_status, o_out_byte);
                mismatch_cnt++;
            end else begin
                want_result = expected_results.pop_front();
                results_checked++;
                status_count[want_result.status]++;
                check_field("status", LEN_W'(want_result.status), LEN_W'(o_status));
                check_field("out_byte", LEN_W'(want_result.out_byte), LEN_W'(o_out_byte));
                check_field("last_of_message", LEN_W'(want_result.last_of_message),
                            LEN_W'(o_last_of_message));
                check_field("message_size", want_result.message_size, o_message_size);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output back-pressure: bursts of stall between stretches of free flow, until quiet_tail is set
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(100, 300)) @(posedge i_clk);
            else repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet_tail) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= KIND_START;
        i_msg_length <= '0;
        i_data_byte <= '0;
        in_idle_on = 1'b1;
        quiet_tail = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_room_check();
        test_random_traffic();
        test_back_to_back();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d starts, %0d bytes, %0d reads, %0d of the unused kind",
                 requests_sent, kind_count[KIND_START], kind_count[KIND_BYTE],
                 kind_count[KIND_READ], kind_count[KIND_UNUSED]);
        $display("checked %0d results: ok %0d, no room %0d, none ready %0d, out of order %0d",
                 results_checked, status_count[ST_OK], status_count[ST_NO_ROOM],
                 status_count[ST_NONE_READY], status_count[ST_ORDER]);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
